// ===== rtl/core/ftcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftcd_pkg
// shared types, constants and coefficient lookup of the tilt change detector
// ----------------------------------------------------------------------------
package ftcd_pkg;

    localparam int TAPS      = 16;
    localparam int TAP_W     = 4;
    localparam int AXES      = 3;
    localparam int SMP_W     = 8;
    localparam int COEF_W    = 23;
    localparam int PROD_W    = SMP_W + COEF_W;
    localparam int FIR_W     = 32;
    localparam int HALF_W    = 16;
    localparam int DPROD_W   = 2 * HALF_W;
    localparam int DOT_W     = 34;
    localparam int THR_W     = 31;
    localparam int LEN_W     = 7;
    localparam int SEC_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;

    localparam logic [THR_W-1:0] THR_RST = 31'd102746112;
    localparam logic [LEN_W-1:0] LEN_RST = 7'd25;

    localparam logic [CFG_IDX_W-1:0] REG_TILT_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LENGTH = 2'd1;

    typedef struct packed {
        logic signed [SMP_W-1:0] x_sample;
        logic signed [SMP_W-1:0] y_sample;
        logic signed [SMP_W-1:0] z_sample;
    } smp_word_t;

    typedef struct packed {
        logic                    decimated;
        logic                    angle_changed;
        logic                    tilt_ok;
        logic                    is_settled;
        logic signed [FIR_W-1:0] filtered_x;
        logic signed [FIR_W-1:0] filtered_y;
        logic signed [FIR_W-1:0] filtered_z;
        logic [SEC_W-1:0]        interval_count;
    } res_word_t;

    typedef logic [AXES-1:0][FIR_W-1:0]  fir_vec_t;
    typedef logic [AXES-1:0][HALF_W-1:0] ref_vec_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIR,
        S_DOT,
        S_DONE
    } ftcd_state_t;

    function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] j);
        logic [TAP_W-1:0] m;
        logic signed [COEF_W-1:0] c;
        begin
            m = j[TAP_W-1] ? ~j : j;
            case (m)
                4'd0:    c = 23'sd133756;
                4'd1:    c = 23'sd213239;
                4'd2:    c = 23'sd435727;
                4'd3:    c = 23'sd779334;
                4'd4:    c = 23'sd1191587;
                4'd5:    c = 23'sd1599781;
                4'd6:    c = 23'sd1926767;
                4'd7:    c = 23'sd2108413;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ftcd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftcd_if
// valid/ready channels for sample words and result words
// ----------------------------------------------------------------------------
interface ftcd_in_if;
    import ftcd_pkg::*;
    logic      valid;
    logic      ready;
    smp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ftcd_out_if;
    import ftcd_pkg::*;
    logic      valid;
    logic      ready;
    res_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ftcd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftcd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ftcd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ftcd_fir.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftcd_fir
// sample ring memory and three-lane tap walking multiply-accumulate
// ----------------------------------------------------------------------------
module ftcd_fir (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [ftcd_pkg::TAP_W-1:0] wr_addr,
    input  wire ftcd_pkg::smp_word_t        wr_data,
    input  wire logic                       start,
    input  wire logic [ftcd_pkg::TAP_W-1:0] newest,
    output logic                            done,
    output ftcd_pkg::fir_vec_t              fir
);
    import ftcd_pkg::*;

    logic [TAPS-1:0]          vld_reg;
    logic                     issue_reg;
    logic [TAP_W-1:0]         cnt_reg;
    logic [TAP_W-1:0]         newest_reg;
    logic                     s1_vld_reg;
    logic                     s1_last_reg;
    logic [TAP_W-1:0]         s1_tap_reg;
    logic                     rd_vld_reg;
    logic                     p_vld_reg;
    logic                     p_last_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] prod_reg [AXES];
    logic signed [FIR_W-1:0]  acc_reg  [AXES];
    logic signed [FIR_W-1:0]  acc_next [AXES];
    fir_vec_t                 fir_reg;
    logic [TAP_W-1:0]         rd_addr;
    logic [AXES*SMP_W-1:0]    ram_rdata;
    smp_word_t                rd_w;
    logic signed [SMP_W-1:0]  samp [AXES];
    logic signed [COEF_W-1:0] coef;

    assign rd_addr = newest_reg - cnt_reg;

    ftcd_ram #(
        .WIDTH (AXES * SMP_W),
        .DEPTH (TAPS)
    ) u_ring (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (issue_reg),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    always_comb
    begin
        rd_w    = rd_vld_reg ? smp_word_t'(ram_rdata) : '0;
        samp[0] = rd_w.x_sample;
        samp[1] = rd_w.y_sample;
        samp[2] = rd_w.z_sample;
        coef    = coef_at(s1_tap_reg);
        for (int a = 0; a < AXES; a++)
        begin
            acc_next[a] = acc_reg[a] + FIR_W'(prod_reg[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            issue_reg   <= 1'b0;
            cnt_reg     <= '0;
            newest_reg  <= '0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s1_tap_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            p_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
            fir_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (start)
            begin
                issue_reg  <= 1'b1;
                cnt_reg    <= '0;
                newest_reg <= newest;
            end
            else if (issue_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == TAP_W'(TAPS - 1))
                begin
                    issue_reg <= 1'b0;
                end
            end
            s1_vld_reg  <= issue_reg;
            s1_last_reg <= issue_reg && (cnt_reg == TAP_W'(TAPS - 1));
            s1_tap_reg  <= cnt_reg;
            rd_vld_reg  <= vld_reg[rd_addr];
            p_vld_reg   <= s1_vld_reg;
            p_last_reg  <= s1_last_reg;
            done_reg    <= p_last_reg;
            if (p_last_reg)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    fir_reg[a] <= acc_next[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            prod_reg[a] <= samp[a] * coef;
            if (start)
            begin
                acc_reg[a] <= '0;
            end
            else if (p_vld_reg)
            begin
                acc_reg[a] <= acc_next[a];
            end
        end
    end

    assign done = done_reg;
    assign fir  = fir_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ftcd_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftcd_dot
// serial dot product of reference and filtered vector, threshold compare
// ----------------------------------------------------------------------------
module ftcd_dot (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire ftcd_pkg::ref_vec_t         ref_vec,
    input  wire ftcd_pkg::fir_vec_t         fir,
    input  wire logic [ftcd_pkg::THR_W-1:0] threshold,
    output logic                            done,
    output logic                            above
);
    import ftcd_pkg::*;

    logic                      run_reg;
    logic [1:0]                cnt_reg;
    logic                      p_vld_reg;
    logic                      p_last_reg;
    logic                      c_vld_reg;
    logic                      done_reg;
    logic                      above_reg;
    logic signed [DPROD_W-1:0] prod_reg;
    logic signed [DOT_W-1:0]   acc_reg;
    logic signed [DOT_W-1:0]   acc_next;
    logic signed [HALF_W-1:0]  ref_a;
    logic signed [HALF_W-1:0]  cur_a;
    logic                      last;

    assign ref_a    = $signed(ref_vec[cnt_reg]);
    assign cur_a    = $signed(fir[cnt_reg][FIR_W-1 -: HALF_W]);
    assign acc_next = acc_reg + DOT_W'(prod_reg);
    assign last     = (cnt_reg == 2'(AXES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            cnt_reg    <= '0;
            p_vld_reg  <= 1'b0;
            p_last_reg <= 1'b0;
            c_vld_reg  <= 1'b0;
            done_reg   <= 1'b0;
            above_reg  <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg <= 1'b0;
                end
            end
            p_vld_reg  <= run_reg;
            p_last_reg <= run_reg && last;
            c_vld_reg  <= p_last_reg;
            done_reg   <= c_vld_reg;
            if (c_vld_reg)
            begin
                above_reg <= acc_reg > $signed({3'b000, threshold});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ref_a * cur_a;
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (p_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done  = done_reg;
    assign above = above_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fir_tilt_change_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_tilt_change_detector
// decimating low-pass fir over x/y/z samples with tilt change detection
//
//  channel  dir  handshake     word
//  smp      in   valid/ready   smp_word_t   one x/y/z sample
//  res      out  valid/ready   res_word_t   one result per sample
//  cfg      in   cfg_we        cfg_index, cfg_data
//
//  a sample that is not decimated skips the filter and goes to the done state
//  a decimated sample takes 16 tap reads from the ring ram
//  through the three-lane mac, then 3 serial products of the dot unit
//  one sample in flight; smp is taken while a result waits on res
//  a stalled res holds the next finished result in the done state
//  reset clears control state; the ring reads as zero until written
// ----------------------------------------------------------------------------
module fir_tilt_change_detector #(
    parameter int DECIMATION = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ftcd_in_if.sink                             smp,
    ftcd_out_if.source                          res,
    input  wire logic                           cfg_we,
    input  wire logic [ftcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ftcd_pkg::CFG_W-1:0]     cfg_data
);
    import ftcd_pkg::*;

    localparam int PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    ftcd_state_t       state_reg, state_next;
    logic [TAP_W-1:0]  widx_reg;
    logic [PH_W-1:0]   phase_reg;
    logic              dec_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  cdown_reg, cdown_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic              settled_reg, settled_next;
    logic              good_reg, good_next;
    ref_vec_t          ref_reg;
    logic              out_valid_reg;
    res_word_t         out_data_reg;

    logic              accept;
    logic              out_free;
    logic              commit;
    logic              fir_start;
    logic              dot_start;
    logic              fir_done;
    logic              dot_done;
    logic              above;
    fir_vec_t          fir;
    logic              tilt;
    logic              changed;
    logic              capture;
    logic [LEN_W-1:0]  cd;
    logic              g;

    assign accept   = smp.valid && smp.ready;
    assign out_free = !out_valid_reg || res.ready;

    ftcd_fir u_fir (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (widx_reg),
        .wr_data (smp.data),
        .start   (fir_start),
        .newest  (widx_reg),
        .done    (fir_done),
        .fir     (fir)
    );

    ftcd_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dot_start),
        .ref_vec   (ref_reg),
        .fir       (fir),
        .threshold (thr_reg),
        .done      (dot_done),
        .above     (above)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (phase_reg == '0) ? S_FIR : S_DONE;
                end
            end
            S_FIR:
            begin
                if (fir_done)
                begin
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                if (dot_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        smp.ready = 1'b0;
        fir_start = 1'b0;
        dot_start = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                smp.ready = 1'b1;
                fir_start = smp.valid && (phase_reg == '0);
            end
            S_FIR:
            begin
                dot_start = fir_done;
            end
            S_DOT:
            begin
            end
            S_DONE:
            begin
                commit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // interval bookkeeping for the finished word
    always_comb
    begin
        cdown_next   = cdown_reg;
        sec_next     = sec_reg;
        settled_next = settled_reg;
        good_next    = good_reg;
        tilt         = 1'b0;
        changed      = 1'b0;
        capture      = 1'b0;
        cd           = cdown_reg - 1'b1;
        g            = good_reg;
        if (dec_reg)
        begin
            cdown_next = cd;
            if (settled_reg)
            begin
                tilt = above;
                g    = good_reg || above;
                good_next = g;
                if (cd == '0)
                begin
                    changed      = !g;
                    settled_next = g;
                    good_next    = 1'b0;
                    cdown_next   = len_reg;
                    sec_next     = sec_reg + 1'b1;
                end
            end
            else if (cd == '0)
            begin
                cdown_next   = len_reg;
                sec_next     = '0;
                settled_next = 1'b1;
                good_next    = 1'b1;
                capture      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            widx_reg      <= '0;
            phase_reg     <= '0;
            dec_reg       <= 1'b0;
            thr_reg       <= THR_RST;
            len_reg       <= LEN_RST;
            cdown_reg     <= LEN_RST;
            sec_reg       <= '0;
            settled_reg   <= 1'b0;
            good_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TILT_THRESHOLD:  thr_reg <= cfg_data[THR_W-1:0];
                    REG_INTERVAL_LENGTH: len_reg <= cfg_data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                widx_reg <= widx_reg + 1'b1;
                dec_reg  <= (phase_reg == '0);
                if ((widx_reg == TAP_W'(TAPS - 1)) || (phase_reg == PH_W'(DECIMATION - 1)))
                begin
                    phase_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + 1'b1;
                end
            end
            if (commit)
            begin
                cdown_reg     <= cdown_next;
                sec_reg       <= sec_next;
                settled_reg   <= settled_next;
                good_reg      <= good_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg.decimated      <= dec_reg;
            out_data_reg.angle_changed  <= changed;
            out_data_reg.tilt_ok        <= tilt;
            out_data_reg.is_settled     <= settled_next;
            out_data_reg.filtered_x     <= $signed(fir[0]);
            out_data_reg.filtered_y     <= $signed(fir[1]);
            out_data_reg.filtered_z     <= $signed(fir[2]);
            out_data_reg.interval_count <= sec_next;
            if (capture)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    ref_reg[a] <= fir[a][FIR_W-1 -: HALF_W];
                end
            end
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    a_fir_done_in_fir: assert property (@(posedge clk) disable iff (!rst_n)
        fir_done |-> (state_reg == S_FIR))
        else $error("filter finished outside filter phase");

    a_dot_done_in_dot: assert property (@(posedge clk) disable iff (!rst_n)
        dot_done |-> (state_reg == S_DOT))
        else $error("dot product finished outside dot phase");

    a_change_clears_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.angle_changed) |-> !out_data_reg.is_settled)
        else $error("angle change reported while still settled");

    a_tilt_needs_decimation: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.tilt_ok) |-> out_data_reg.decimated)
        else $error("tilt flagged on a word without filter run");

endmodule
`default_nettype wire
